// ===== rtl/sliding_window_peak_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window peak detector assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_PEAK_DETECTOR_DEFINES_SVH
`define SLIDING_WINDOW_PEAK_DETECTOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define SWPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swpd check failed");

// Consequent checked in the cycle after the antecedent
`define SWPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swpd check failed");

`endif

// ===== rtl/swpd_pkg.sv =====
// ----------------------------------------------------------------------------
// swpd_pkg
// Types and constants shared by the sliding window peak detector modules.
// ----------------------------------------------------------------------------
package swpd_pkg;

    localparam int TIME_W     = 40;
    localparam int VALUE_W    = 32;
    localparam int WLEN_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;

    // x / 5 == (x * 205) >> 10 for every x below 1024
    localparam int MID_RECIP = 205;
    localparam int MID_SHIFT = 10;

    typedef logic [TIME_W-1:0]         stamp_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LEN     = 2'd0,
        REG_PEAK_THRESHOLD = 2'd1,
        REG_MIN_PEAK_GAP   = 2'd2
    } cfg_reg_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic   shift;
        value_t cand_value;
    } cell_ctrl_t;

endpackage

// ===== rtl/swpd_cell.sv =====
// ----------------------------------------------------------------------------
// swpd_cell
// One history slot: holds a sample, passes it on at each shift and compares
// it against the broadcast candidate.
// ----------------------------------------------------------------------------
module swpd_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6,
    parameter int LEN_W = 7
) (
    input  logic                 clk,
    input  swpd_pkg::cell_ctrl_t ctrl,
    input  logic [LEN_W-1:0]     len,
    input  logic [IDX_W-1:0]     cidx,
    input  swpd_pkg::value_t     value_in,
    input  swpd_pkg::stamp_t     stamp_in,
    output swpd_pkg::value_t     value_out,
    output swpd_pkg::stamp_t     stamp_out,
    output swpd_pkg::value_t     sel_value,
    output swpd_pkg::stamp_t     sel_stamp,
    output logic                 bad
);
    import swpd_pkg::*;

    value_t value_reg;
    stamp_t stamp_reg;
    logic   bad_reg;
    logic   bad_next;
    logic   in_win;
    logic   is_sel;
    logic   earlier;
    logic   later;

    // Position of this slot relative to the window and the candidate
    assign in_win  = LEN_W'(INDEX) < len;
    assign is_sel  = IDX_W'(INDEX) == cidx;
    assign earlier = IDX_W'(INDEX) > cidx;
    assign later   = IDX_W'(INDEX) < cidx;

    // Older entries must be strictly smaller, newer ones not larger
    assign bad_next = in_win && ((earlier && (value_reg >= ctrl.cand_value)) ||
                                 (later && (value_reg > ctrl.cand_value)));

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            value_reg <= value_in;
            stamp_reg <= stamp_in;
        end
        bad_reg <= bad_next;
    end

    assign value_out = value_reg;
    assign stamp_out = stamp_reg;
    assign sel_value = is_sel ? value_reg : '0;
    assign sel_stamp = is_sel ? stamp_reg : '0;
    assign bad       = bad_reg;

endmodule

// ===== rtl/sliding_window_peak_detector.sv =====
// ----------------------------------------------------------------------------
// sliding_window_peak_detector
// Non-maximum suppression over a sliding window of timestamped samples.
// ----------------------------------------------------------------------------
// Input channel: sample_time / sample_value with in_valid, in_stall. An item
// is taken when in_valid is high and in_stall low. Output channel: peak_time
// / peak_value with out_valid, out_stall; at most one result per item.
// Each item shifts into a chain of MAX_WINDOW cells. Once more samples have
// arrived than the window holds, the entry at (len-1)/5 from the oldest is
// selected, every cell compares itself against it, and the flags are
// reduced together with the threshold and minimum-gap tests.
// Each item steps through the select, compare and reduce steps of the
// sequencer (select only when too few samples are held); no new item is
// taken until it is idle again. A peak is loaded in the reduce step.
// The result sits in an output register; the next item is taken while it
// waits. If a new peak is ready while the output is still stalled, the
// sequencer holds in its last step and in_stall stays high.
// Reset clears the sample count, the last peak time, the output valid and
// loads the configuration defaults (window 16, threshold 0, gap 0).
// Configuration is written through cfg_write_en / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
module sliding_window_peak_detector #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  swpd_pkg::stamp_t                   sample_time,
    input  swpd_pkg::value_t                   sample_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output swpd_pkg::stamp_t                   peak_time,
    output swpd_pkg::value_t                   peak_value,
    input  logic                               cfg_write_en,
    input  logic [swpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import swpd_pkg::*;

    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int FILL_W = $clog2(MAX_WINDOW + 2);
    localparam int CMP_W  = WLEN_W + LEN_W;
    localparam int PROD_W = LEN_W + 11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_CMP,
        S_DEC
    } state_t;

    state_t            state_reg;
    logic [WLEN_W-1:0] window_len_reg;
    value_t            peak_threshold_reg;
    logic [31:0]       min_peak_gap_reg;
    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;
    stamp_t            last_peak_reg;
    logic              out_valid_reg;
    stamp_t            peak_time_reg;
    value_t            peak_value_reg;

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [IDX_W-1:0]  cidx_reg;
    logic [IDX_W-1:0]  cidx_next;
    logic              test_reg;
    logic              test_next;
    value_t            cand_value_reg;
    stamp_t            cand_stamp_reg;
    logic              gap_ok_reg;
    logic              thr_ok_reg;

    logic [CMP_W-1:0]  wlen_ext;
    logic [LEN_W-1:0]  len_m1;
    logic [PROD_W-1:0] mid_prod;
    logic [IDX_W-1:0]  mid;
    logic [TIME_W:0]   gap_diff;
    logic [TIME_W:0]   gap_min;
    logic              gap_ok;
    logic              accept;
    logic              slot_free;
    logic              peak_hit;
    logic              out_load;
    cell_ctrl_t        cell_ctrl;

    value_t            chain_value [MAX_WINDOW];
    stamp_t            chain_stamp [MAX_WINDOW];
    value_t            sel_value   [MAX_WINDOW];
    stamp_t            sel_stamp   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] bad_vec;
    value_t            sel_value_or;
    stamp_t            sel_stamp_or;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    // Effective window length, clamped to 1..MAX_WINDOW
    assign wlen_ext = CMP_W'(window_len_reg);
    always_comb
    begin
        if (window_len_reg == '0)
            len_next = LEN_W'(1);
        else if (wlen_ext > CMP_W'(MAX_WINDOW))
            len_next = LEN_W'(MAX_WINDOW);
        else
            len_next = LEN_W'(window_len_reg);
    end

    // Candidate history index: len-1 - (len-1)/5
    assign len_m1    = len_next - LEN_W'(1);
    assign mid_prod  = PROD_W'(len_m1) * PROD_W'(MID_RECIP);
    assign mid       = IDX_W'(mid_prod >> MID_SHIFT);
    assign cidx_next = IDX_W'(len_m1) - mid;

    // Saturating sample count and test enable
    assign fill_count_next = (fill_count_reg < FILL_W'(MAX_WINDOW + 1)) ?
                             fill_count_reg + FILL_W'(1) : fill_count_reg;
    assign test_next = fill_count_next > FILL_W'(len_next);

    // Gap test on a signed difference
    assign gap_diff = {1'b0, cand_stamp_reg} - {1'b0, last_peak_reg};
    assign gap_min  = (TIME_W + 1)'(min_peak_gap_reg);
    assign gap_ok   = (last_peak_reg == '0) || !($signed(gap_diff) < $signed(gap_min));

    assign peak_hit = gap_ok_reg && thr_ok_reg && !(|bad_vec);

    // Output register loads once the decision is made and the slot is free
    assign out_load = (state_reg == S_DEC) && peak_hit && slot_free;

    assign cell_ctrl.shift      = accept;
    assign cell_ctrl.cand_value = cand_value_reg;

    // Cell chain: cell 0 holds the newest sample
    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                swpd_cell #(
                    .INDEX (gi),
                    .IDX_W (IDX_W),
                    .LEN_W (LEN_W)
                ) u_cell (
                    .clk       (clk),
                    .ctrl      (cell_ctrl),
                    .len       (len_reg),
                    .cidx      (cidx_reg),
                    .value_in  (sample_value),
                    .stamp_in  (sample_time),
                    .value_out (chain_value[gi]),
                    .stamp_out (chain_stamp[gi]),
                    .sel_value (sel_value[gi]),
                    .sel_stamp (sel_stamp[gi]),
                    .bad       (bad_vec[gi])
                );
            end
            else
            begin : g_body
                swpd_cell #(
                    .INDEX (gi),
                    .IDX_W (IDX_W),
                    .LEN_W (LEN_W)
                ) u_cell (
                    .clk       (clk),
                    .ctrl      (cell_ctrl),
                    .len       (len_reg),
                    .cidx      (cidx_reg),
                    .value_in  (chain_value[gi-1]),
                    .stamp_in  (chain_stamp[gi-1]),
                    .value_out (chain_value[gi]),
                    .stamp_out (chain_stamp[gi]),
                    .sel_value (sel_value[gi]),
                    .sel_stamp (sel_stamp[gi]),
                    .bad       (bad_vec[gi])
                );
            end
        end
    endgenerate

    // Only the selected cell drives a nonzero value, so OR them together
    always_comb
    begin
        sel_value_or = '0;
        sel_stamp_or = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            sel_value_or = sel_value_or | sel_value[i];
            sel_stamp_or = sel_stamp_or | sel_stamp[i];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg     <= WLEN_RESET;
            peak_threshold_reg <= '0;
            min_peak_gap_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_WINDOW_LEN:     window_len_reg     <= cfg_data[WLEN_W-1:0];
                REG_PEAK_THRESHOLD: peak_threshold_reg <= value_t'(cfg_data);
                REG_MIN_PEAK_GAP:   min_peak_gap_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Datapath registers for the item in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg  <= len_next;
            cidx_reg <= cidx_next;
            test_reg <= test_next;
        end
        if (state_reg == S_SEL)
        begin
            cand_value_reg <= sel_value_or;
            cand_stamp_reg <= sel_stamp_or;
        end
        if (state_reg == S_CMP)
        begin
            gap_ok_reg <= gap_ok;
            thr_ok_reg <= cand_value_reg > peak_threshold_reg;
        end
    end

    // Sequencer, count, last peak and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            last_peak_reg  <= '0;
            out_valid_reg  <= 1'b0;
            peak_time_reg  <= '0;
            peak_value_reg <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        fill_count_reg <= fill_count_next;
                        state_reg      <= S_SEL;
                    end
                end
                S_SEL:
                begin
                    state_reg <= test_reg ? S_CMP : S_IDLE;
                end
                S_CMP:
                begin
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    if (!peak_hit)
                        state_reg <= S_IDLE;
                    else if (slot_free)
                    begin
                        peak_time_reg  <= cand_stamp_reg;
                        peak_value_reg <= cand_value_reg;
                        last_peak_reg  <= cand_stamp_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign peak_time  = peak_time_reg;
    assign peak_value = peak_value_reg;

endmodule

// ===== rtl/swpd_checker.sv =====
// ----------------------------------------------------------------------------
// swpd_checker
// Port-level checks for the sliding window peak detector, bound to the top.
// ----------------------------------------------------------------------------
`include "sliding_window_peak_detector_defines.svh"

module swpd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input swpd_pkg::stamp_t peak_time,
    input swpd_pkg::value_t peak_value
);
    import swpd_pkg::*;

    // A stalled result stays put
    `SWPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(peak_time) && $stable(peak_value))

    // One item in flight: the cycle after an item is taken the input stalls
    `SWPD_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

    // A fresh result comes from an earlier taken item, and the input is free again
    `SWPD_ASSERT_IMPL(a_peak_latency, $rose(out_valid), $past(in_valid && !in_stall, 4) && !in_stall)

endmodule

bind sliding_window_peak_detector swpd_checker u_swpd_checker (.*);
